// ----- design/sobc_pkg.sv -----
package sobc_pkg;

    localparam int NUM_CHANNELS          = 6;
    localparam int SAMPLE_W              = 16;
    localparam int BOUND_W               = 15;
    localparam int GRAVITY_W             = 15;
    localparam int GRAVITY_RESET         = 8192;
    localparam int SAMPLES_PER_ROUND_DEF = 20;
    localparam int SEARCH_LIMIT_DEF      = 8192;

    // channel order of the sample set
    localparam int CH_ACCEL_X = 0;
    localparam int CH_ACCEL_Y = 1;
    localparam int CH_ACCEL_Z = 2;
    localparam int CH_GYRO_X  = 3;
    localparam int CH_GYRO_Y  = 4;
    localparam int CH_GYRO_Z  = 5;

    // per-item control from the sequencer to every channel
    typedef struct packed {
        logic step;       // an item moves into the result register
        logic start;      // restart the search from full bounds
        logic accum;      // add this sample set to the sums
        logic round_end;  // last sample of the round
        logic apply;      // load the new midpoints into the applied offsets
    } ctrl_t;

    // (hi + lo) / 2, truncated toward zero
    function automatic logic signed [BOUND_W-1:0] midpoint(
        input logic signed [BOUND_W-1:0] hi,
        input logic signed [BOUND_W-1:0] lo
    );
        logic signed [BOUND_W:0] s;
        logic signed [BOUND_W:0] r;
        s = $signed({hi[BOUND_W-1], hi}) + $signed({lo[BOUND_W-1], lo});
        r = s + $signed({{BOUND_W{1'b0}}, s[BOUND_W]});
        return BOUND_W'(r >>> 1);
    endfunction

endpackage

// ----- design/sobc_channel.sv -----
module sobc_channel #(
    parameter int SAMPLES_PER_ROUND = sobc_pkg::SAMPLES_PER_ROUND_DEF,
    parameter int SEARCH_LIMIT      = sobc_pkg::SEARCH_LIMIT_DEF,
    parameter int THR_W             = 16 + $clog2(SAMPLES_PER_ROUND)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sobc_pkg::ctrl_t                       ctrl,
    input  logic signed [sobc_pkg::SAMPLE_W-1:0]  sample,
    input  logic [THR_W-1:0]                      threshold,
    output logic signed [sobc_pkg::BOUND_W-1:0]   offset,
    output logic                                  converged
);

    localparam int SUM_W = sobc_pkg::SAMPLE_W + $clog2(SAMPLES_PER_ROUND);
    localparam int CMP_W = THR_W + 1;
    localparam int BW    = sobc_pkg::BOUND_W;

    localparam logic signed [BW-1:0] LOWER_INIT = BW'(-SEARCH_LIMIT);
    localparam logic signed [BW-1:0] UPPER_INIT = BW'(SEARCH_LIMIT);

    logic signed [BW-1:0]    lower_reg;
    logic signed [BW-1:0]    lower_next;
    logic signed [BW-1:0]    upper_reg;
    logic signed [BW-1:0]    upper_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [BW-1:0]    applied_reg;
    logic signed [BW-1:0]    applied_next;

    logic signed [SUM_W-1:0] sum_add;
    logic                    above;
    logic signed [BW-1:0]    mid_now;
    logic signed [BW-1:0]    lower_upd;
    logic signed [BW-1:0]    upper_upd;
    logic signed [BW:0]      span;

    assign sum_add = sum_reg + SUM_W'(sample);

    // truncated average above the expected value (expected >= 0):
    // sum >= (expected + 1) * samples per round
    assign above = $signed(CMP_W'(sum_add)) >= $signed({1'b0, threshold});

    assign mid_now   = sobc_pkg::midpoint(upper_reg, lower_reg);
    assign upper_upd = above ? mid_now : upper_reg;
    assign lower_upd = above ? lower_reg : mid_now;

    assign span      = $signed({upper_upd[BW-1], upper_upd})
                     - $signed({lower_upd[BW-1], lower_upd});
    assign converged = span <= $signed((BW + 1)'(1));

    always_comb
    begin
        lower_next   = lower_reg;
        upper_next   = upper_reg;
        sum_next     = sum_reg;
        applied_next = applied_reg;
        if (ctrl.step)
        begin
            priority if (ctrl.start)
            begin
                lower_next   = LOWER_INIT;
                upper_next   = UPPER_INIT;
                sum_next     = '0;
                applied_next = sobc_pkg::midpoint(UPPER_INIT, LOWER_INIT);
            end
            else if (ctrl.accum && ctrl.round_end)
            begin
                lower_next = lower_upd;
                upper_next = upper_upd;
                sum_next   = '0;
                if (ctrl.apply)
                begin
                    applied_next = sobc_pkg::midpoint(upper_upd, lower_upd);
                end
            end
            else if (ctrl.accum)
            begin
                sum_next = sum_add;
            end
            else
            begin
                // settling or idle: hold
                sum_next = sum_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg   <= LOWER_INIT;
            upper_reg   <= UPPER_INIT;
            sum_reg     <= '0;
            applied_reg <= '0;
        end
        else
        begin
            lower_reg   <= lower_next;
            upper_reg   <= upper_next;
            sum_reg     <= sum_next;
            applied_reg <= applied_next;
        end
    end

    assign offset = applied_reg;

endmodule

// ----- design/sobc_control.sv -----
module sobc_control #(
    parameter int SAMPLES_PER_ROUND = sobc_pkg::SAMPLES_PER_ROUND_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic            start_op,
    input  logic            all_converged,
    output sobc_pkg::ctrl_t ctrl,
    output logic            calibrating,
    output logic            finished
);

    localparam int CNT_W = $clog2(SAMPLES_PER_ROUND + 1);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SETTLE = 2'd1;
    localparam logic [1:0] PH_ACCUM  = 2'd2;

    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(SAMPLES_PER_ROUND - 1);

    logic [1:0]       phase_reg;
    logic [1:0]       phase_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             calibrating_reg;
    logic             calibrating_next;
    logic             finished_reg;
    logic             finished_next;

    logic             accum;
    logic             round_end;

    assign accum     = !start_op && (phase_reg == PH_ACCUM);
    assign round_end = accum && (count_reg == LAST_COUNT);

    assign ctrl.step      = step;
    assign ctrl.start     = start_op;
    assign ctrl.accum     = accum;
    assign ctrl.round_end = round_end;
    assign ctrl.apply     = round_end && !all_converged;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        priority if (start_op)
        begin
            phase_next = PH_SETTLE;
            count_next = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_SETTLE:
                begin
                    // drop the settling sample
                    phase_next = PH_ACCUM;
                end
                PH_ACCUM:
                begin
                    if (round_end)
                    begin
                        phase_next = all_converged ? PH_IDLE : PH_SETTLE;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        calibrating_next = (phase_next != PH_IDLE);
        finished_next    = round_end && all_converged;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            count_reg       <= '0;
            calibrating_reg <= 1'b0;
            finished_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            count_reg       <= count_next;
            calibrating_reg <= calibrating_next;
            finished_reg    <= finished_next;
        end
    end

    assign calibrating = calibrating_reg;
    assign finished    = finished_reg;

endmodule

// ----- design/sensor_offset_bisection_calibrator.sv -----
// Channel  Handshake                    Payload
// in       in_valid / in_stall          operation, accel_x..z, gyro_x..z
// out      out_valid / out_stall        offset_accel_x..offset_gyro_z, calibrating, finished
// cfg      cfg_write_enable             cfg_write_data (gravity reference)
//
// Two register stages: input register, then the result register. One item per
// cycle sustained while out is not stalled. Each item updates all six channels side
// by side in the cycle it leaves the input register. Reset clears the bounds to full
// span, sums, offsets and sequencer. A stall on out holds the result and backs up
// into in_stall.
module sensor_offset_bisection_calibrator #(
    parameter int SAMPLES_PER_ROUND = sobc_pkg::SAMPLES_PER_ROUND_DEF,
    parameter int SEARCH_LIMIT      = sobc_pkg::SEARCH_LIMIT_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write_enable,
    input  logic [sobc_pkg::GRAVITY_W-1:0]         cfg_write_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   operation,
    input  logic signed [sobc_pkg::SAMPLE_W-1:0]   accel_x,
    input  logic signed [sobc_pkg::SAMPLE_W-1:0]   accel_y,
    input  logic signed [sobc_pkg::SAMPLE_W-1:0]   accel_z,
    input  logic signed [sobc_pkg::SAMPLE_W-1:0]   gyro_x,
    input  logic signed [sobc_pkg::SAMPLE_W-1:0]   gyro_y,
    input  logic signed [sobc_pkg::SAMPLE_W-1:0]   gyro_z,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [sobc_pkg::BOUND_W-1:0]    offset_accel_x,
    output logic signed [sobc_pkg::BOUND_W-1:0]    offset_accel_y,
    output logic signed [sobc_pkg::BOUND_W-1:0]    offset_accel_z,
    output logic signed [sobc_pkg::BOUND_W-1:0]    offset_gyro_x,
    output logic signed [sobc_pkg::BOUND_W-1:0]    offset_gyro_y,
    output logic signed [sobc_pkg::BOUND_W-1:0]    offset_gyro_z,
    output logic                                   calibrating,
    output logic                                   finished
);

    localparam int NCH   = sobc_pkg::NUM_CHANNELS;
    localparam int THR_W = 16 + $clog2(SAMPLES_PER_ROUND);

    localparam logic [THR_W-1:0] THR_RESET =
        THR_W'((sobc_pkg::GRAVITY_RESET + 1) * SAMPLES_PER_ROUND);
    localparam logic [THR_W-1:0] THR_ZERO = THR_W'(SAMPLES_PER_ROUND);

    logic                                  s1_valid_reg;
    logic                                  s1_valid_next;
    logic                                  op_reg;
    logic signed [sobc_pkg::SAMPLE_W-1:0]  sample_reg [NCH];
    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    logic [THR_W-1:0]                      thr_reg;
    logic [THR_W-1:0]                      thr_calc;

    logic                                  in_xfer;
    logic                                  advance;
    logic [NCH-1:0]                        conv;
    logic signed [sobc_pkg::BOUND_W-1:0]   offset [NCH];
    sobc_pkg::ctrl_t                       ctrl;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    assign s1_valid_next  = in_xfer ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_valid_reg && out_stall);

    // accel z threshold: (gravity + 1) * samples per round
    assign thr_calc = THR_W'((THR_W'(cfg_write_data) + THR_W'(1))
                             * THR_W'(SAMPLES_PER_ROUND));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            thr_reg       <= THR_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_enable)
            begin
                thr_reg <= thr_calc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg                           <= operation;
            sample_reg[sobc_pkg::CH_ACCEL_X] <= accel_x;
            sample_reg[sobc_pkg::CH_ACCEL_Y] <= accel_y;
            sample_reg[sobc_pkg::CH_ACCEL_Z] <= accel_z;
            sample_reg[sobc_pkg::CH_GYRO_X]  <= gyro_x;
            sample_reg[sobc_pkg::CH_GYRO_Y]  <= gyro_y;
            sample_reg[sobc_pkg::CH_GYRO_Z]  <= gyro_z;
        end
    end

    sobc_control #(
        .SAMPLES_PER_ROUND (SAMPLES_PER_ROUND)
    ) u_control (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .start_op      (op_reg),
        .all_converged (&conv),
        .ctrl          (ctrl),
        .calibrating   (calibrating),
        .finished      (finished)
    );

    for (genvar c = 0; c < NCH; c++)
    begin : g_channel
        sobc_channel #(
            .SAMPLES_PER_ROUND (SAMPLES_PER_ROUND),
            .SEARCH_LIMIT      (SEARCH_LIMIT),
            .THR_W             (THR_W)
        ) u_channel (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .sample    (sample_reg[c]),
            .threshold ((c == sobc_pkg::CH_ACCEL_Z) ? thr_reg : THR_ZERO),
            .offset    (offset[c]),
            .converged (conv[c])
        );
    end

    assign out_valid      = out_valid_reg;
    assign offset_accel_x = offset[sobc_pkg::CH_ACCEL_X];
    assign offset_accel_y = offset[sobc_pkg::CH_ACCEL_Y];
    assign offset_accel_z = offset[sobc_pkg::CH_ACCEL_Z];
    assign offset_gyro_x  = offset[sobc_pkg::CH_GYRO_X];
    assign offset_gyro_y  = offset[sobc_pkg::CH_GYRO_Y];
    assign offset_gyro_z  = offset[sobc_pkg::CH_GYRO_Z];

endmodule

// ----- tb/sv/sensor_offset_bisection_calibrator_tb.sv -----
`timescale 1ns / 1ps

module sensor_offset_bisection_calibrator_tb;

    localparam int NUM_CHANNELS          = sobc_pkg::NUM_CHANNELS;
    localparam int SAMPLE_W              = sobc_pkg::SAMPLE_W;
    localparam int BOUND_W               = sobc_pkg::BOUND_W;
    localparam int GRAVITY_W             = sobc_pkg::GRAVITY_W;
    localparam int GRAVITY_RESET         = sobc_pkg::GRAVITY_RESET;
    localparam int SAMPLES_PER_ROUND_DEF = sobc_pkg::SAMPLES_PER_ROUND_DEF;
    localparam int SEARCH_LIMIT_DEF      = sobc_pkg::SEARCH_LIMIT_DEF;
    localparam int CH_ACCEL_X            = sobc_pkg::CH_ACCEL_X;
    localparam int CH_ACCEL_Y            = sobc_pkg::CH_ACCEL_Y;
    localparam int CH_ACCEL_Z            = sobc_pkg::CH_ACCEL_Z;
    localparam int CH_GYRO_X             = sobc_pkg::CH_GYRO_X;
    localparam int CH_GYRO_Y             = sobc_pkg::CH_GYRO_Y;
    localparam int CH_GYRO_Z             = sobc_pkg::CH_GYRO_Z;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_START  = 1'b1;

    typedef enum logic [1:0] {
        SEARCH_IDLE,
        SEARCH_SETTLE,
        SEARCH_SUM
    } search_state_t;

    typedef logic [NUM_CHANNELS-1:0][SAMPLE_W-1:0] samples_t;

    typedef struct packed {
        logic [NUM_CHANNELS-1:0][BOUND_W-1:0] offset;
        logic                                 calibrating;
        logic                                 finished;
    } offsets_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_write_enable;
    logic [GRAVITY_W-1:0]        cfg_write_data;
    logic                        in_valid;
    logic                        in_stall;
    logic                        operation;
    logic signed [SAMPLE_W-1:0]  accel_x;
    logic signed [SAMPLE_W-1:0]  accel_y;
    logic signed [SAMPLE_W-1:0]  accel_z;
    logic signed [SAMPLE_W-1:0]  gyro_x;
    logic signed [SAMPLE_W-1:0]  gyro_y;
    logic signed [SAMPLE_W-1:0]  gyro_z;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [BOUND_W-1:0]   offset_accel_x;
    logic signed [BOUND_W-1:0]   offset_accel_y;
    logic signed [BOUND_W-1:0]   offset_accel_z;
    logic signed [BOUND_W-1:0]   offset_gyro_x;
    logic signed [BOUND_W-1:0]   offset_gyro_y;
    logic signed [BOUND_W-1:0]   offset_gyro_z;
    logic                        calibrating;
    logic                        finished;

    sensor_offset_bisection_calibrator u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .accel_x          (accel_x),
        .accel_y          (accel_y),
        .accel_z          (accel_z),
        .gyro_x           (gyro_x),
        .gyro_y           (gyro_y),
        .gyro_z           (gyro_z),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .offset_accel_x   (offset_accel_x),
        .offset_accel_y   (offset_accel_y),
        .offset_accel_z   (offset_accel_z),
        .offset_gyro_x    (offset_gyro_x),
        .offset_gyro_y    (offset_gyro_y),
        .offset_gyro_z    (offset_gyro_z),
        .calibrating      (calibrating),
        .finished         (finished)
    );

    // search state of the predictor
    int            lo_bound       [NUM_CHANNELS];
    int            hi_bound       [NUM_CHANNELS];
    int            applied_offset [NUM_CHANNELS];
    longint        chan_sum       [NUM_CHANNELS];
    int            round_count;
    search_state_t search_state;
    int            grav_ref;

    // offsets the simulated sensor needs, so that searches converge somewhere real
    int            true_offset    [NUM_CHANNELS];

    offsets_t      expected_offsets [$];

    int mismatches;
    int results_checked;
    int items_sent;
    int searches_started;
    int searches_done;
    int gravity_writes;
    int sender_burst;
    int stall_hold;

    string chan_name [NUM_CHANNELS] = '{"offset_accel_x", "offset_accel_y", "offset_accel_z",
                                        "offset_gyro_x", "offset_gyro_y", "offset_gyro_z"};

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic samples_t any_reading();
        return {$urandom(), $urandom(), $urandom()};
    endfunction

    // reading rises with the applied offset, centered on the expected value
    function automatic samples_t sensor_reading(int noise);
        samples_t s;
        int       v;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            v = ((c == CH_ACCEL_Z) ? grav_ref : 0) + applied_offset[c] - true_offset[c]
                + int'($urandom_range(0, 2 * noise)) - noise;
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            s[c] = v[SAMPLE_W-1:0];
        end
        return s;
    endfunction

    task automatic pick_true_offsets();
        for (int c = 0; c < NUM_CHANNELS; c++)
            true_offset[c] = int'($urandom_range(0, 16000)) - 8000;
    endtask

    task automatic load_midpoints();
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            applied_offset[c] = (hi_bound[c] + lo_bound[c]) / 2;
            chan_sum[c] = 0;
        end
        round_count = 0;
    endtask

    task automatic track_search(input logic op, input samples_t s);
        offsets_t r;
        longint   avg;
        int       target;
        int       mid;
        logic     converged;
        converged = 1'b0;
        if (op == OP_START)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                lo_bound[c] = -SEARCH_LIMIT_DEF;
                hi_bound[c] = SEARCH_LIMIT_DEF;
            end
            load_midpoints();
            search_state = SEARCH_SETTLE;
            searches_started++;
        end
        else if (search_state == SEARCH_SETTLE)
        begin
            // drop the settling sample
            search_state = SEARCH_SUM;
        end
        else if (search_state == SEARCH_SUM)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
                chan_sum[c] += $signed(s[c]);
            round_count++;
            if (round_count >= SAMPLES_PER_ROUND_DEF)
            begin
                converged = 1'b1;
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    target = (c == CH_ACCEL_Z) ? grav_ref : 0;
                    avg = chan_sum[c] / SAMPLES_PER_ROUND_DEF;
                    mid = (hi_bound[c] + lo_bound[c]) / 2;
                    if (avg > target)
                        hi_bound[c] = mid;
                    else
                        lo_bound[c] = mid;
                    if (hi_bound[c] - lo_bound[c] > 1)
                        converged = 1'b0;
                end
                if (converged)
                begin
                    // keep the offsets of the last round applied
                    search_state = SEARCH_IDLE;
                    round_count = 0;
                    for (int c = 0; c < NUM_CHANNELS; c++)
                        chan_sum[c] = 0;
                    searches_done++;
                end
                else
                begin
                    load_midpoints();
                    search_state = SEARCH_SETTLE;
                end
            end
        end
        for (int c = 0; c < NUM_CHANNELS; c++)
            r.offset[c] = BOUND_W'(applied_offset[c]);
        r.calibrating = (search_state != SEARCH_IDLE);
        r.finished = converged;
        expected_offsets.push_back(r);
    endtask

    task automatic send_item(input logic op, input samples_t s);
        int gap;
        if (sender_burst > 0)
        begin
            sender_burst--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 39) == 0)
                sender_burst = $urandom_range(20, 60);
            gap = pick_gap();
        end
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        accel_x   <= s[CH_ACCEL_X];
        accel_y   <= s[CH_ACCEL_Y];
        accel_z   <= s[CH_ACCEL_Z];
        gyro_x    <= s[CH_GYRO_X];
        gyro_y    <= s[CH_GYRO_Y];
        gyro_z    <= s[CH_GYRO_Z];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        track_search(op, s);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_offsets.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_gravity(input int value);
        wait_drained();
        @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= GRAVITY_W'(value);
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        grav_ref = value;
        gravity_writes++;
    endtask

    task automatic send_readings(input int count, input int wild_pct);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < wild_pct)
                send_item(OP_SAMPLE, any_reading());
            else
                send_item(OP_SAMPLE, sensor_reading(40));
        end
    endtask

    // samples while idle, extreme sums, a negative average that truncates to zero,
    // then a restart in the middle of a search
    task automatic test_idle_and_extremes();
        send_item(OP_SAMPLE, {NUM_CHANNELS{16'sh7FFF}});
        send_item(OP_SAMPLE, {NUM_CHANNELS{16'sh8000}});
        send_item(OP_START, any_reading());
        send_item(OP_SAMPLE, any_reading());
        repeat (SAMPLES_PER_ROUND_DEF / 2)
            send_item(OP_SAMPLE, {NUM_CHANNELS{16'sh7FFF}});
        repeat (SAMPLES_PER_ROUND_DEF / 2)
            send_item(OP_SAMPLE, {NUM_CHANNELS{16'sh8000}});
        send_item(OP_START, {NUM_CHANNELS{16'sh8000}});
    endtask

    // one search run to convergence, then hold the result over idle samples
    task automatic test_full_search();
        wait_drained();
        pick_true_offsets();
        send_item(OP_START, any_reading());
        while (search_state != SEARCH_IDLE)
            send_item(OP_SAMPLE, sensor_reading(40));
        repeat (3)
            send_item(OP_SAMPLE, any_reading());
    endtask

    task automatic test_gravity_extremes();
        write_gravity((1 << GRAVITY_W) - 1);
        pick_true_offsets();
        send_item(OP_START, any_reading());
        send_readings(2 * (SAMPLES_PER_ROUND_DEF + 1), 15);
        write_gravity(0);
        send_readings(2 * (SAMPLES_PER_ROUND_DEF + 1), 15);
        write_gravity($urandom_range(0, (1 << GRAVITY_W) - 1));
    endtask

    task automatic test_random_traffic();
        int r;
        for (int i = 0; i < 150; i++)
        begin
            if (i == 75)
                write_gravity($urandom_range(0, (1 << GRAVITY_W) - 1));
            r = $urandom_range(0, 99);
            if (r < 3 || (search_state == SEARCH_IDLE && r < 30))
            begin
                pick_true_offsets();
                send_item(OP_START, any_reading());
            end
            else if (r < 75)
                send_item(OP_SAMPLE, sensor_reading($urandom_range(0, 400)));
            else
                send_item(OP_SAMPLE, any_reading());
        end
    endtask

    // receiver: short and long stalls, with long free stretches now and then
    always @(negedge clk)
    begin
        if (stall_hold > 0)
            stall_hold--;
        else if (out_stall)
        begin
            out_stall <= 1'b0;
            stall_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(0, 6);
        end
        else
        begin
            stall_hold = pick_gap();
            if (stall_hold > 0)
            begin
                out_stall <= 1'b1;
                stall_hold--;
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : check_offsets
        offsets_t                  want;
        logic signed [BOUND_W-1:0] got [NUM_CHANNELS];
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_offsets.size() == 0)
            begin
                $error("result transfer with no expected result waiting");
                mismatches++;
            end
            else
            begin
                want = expected_offsets.pop_front();
                got = '{offset_accel_x, offset_accel_y, offset_accel_z,
                        offset_gyro_x, offset_gyro_y, offset_gyro_z};
                for (int c = 0; c < NUM_CHANNELS; c++)
                    check_field(chan_name[c], $signed(want.offset[c]), got[c]);
                check_field("calibrating", want.calibrating, calibrating);
                check_field("finished", want.finished, finished);
                results_checked++;
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_write_data   = '0;
        in_valid         = 1'b0;
        operation        = OP_SAMPLE;
        accel_x          = '0;
        accel_y          = '0;
        accel_z          = '0;
        gyro_x           = '0;
        gyro_y           = '0;
        gyro_z           = '0;
        out_stall        = 1'b0;
        stall_hold       = 0;
        sender_burst     = 0;
        mismatches       = 0;
        results_checked  = 0;
        items_sent       = 0;
        searches_started = 0;
        searches_done    = 0;
        gravity_writes   = 0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            lo_bound[c]       = -SEARCH_LIMIT_DEF;
            hi_bound[c]       = SEARCH_LIMIT_DEF;
            applied_offset[c] = 0;
            chan_sum[c]       = 0;
            true_offset[c]    = 0;
        end
        round_count  = 0;
        search_state = SEARCH_IDLE;
        grav_ref     = GRAVITY_RESET;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_and_extremes();
        test_full_search();
        test_gravity_extremes();
        test_random_traffic();

        wait_drained();
        repeat (10) @(posedge clk);

        $display("Sent %0d transfers, checked %0d results, %0d gravity settings written",
                 items_sent, results_checked, gravity_writes);
        $display("Searches started %0d, searches converged %0d",
                 searches_started, searches_done);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/sobc_pkg.sv
design/sobc_channel.sv
design/sobc_control.sv
design/sensor_offset_bisection_calibrator.sv
tb/sv/sensor_offset_bisection_calibrator_tb.sv
